// ===== sv/blur5x5_invert_filter_macros.svh =====
// Assertion macros used by the checker of the blur filter.
`ifndef BLUR5X5_INVERT_FILTER_MACROS_SVH
`define BLUR5X5_INVERT_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BWF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("blur filter check failed");

// Next-cycle implication, disabled while reset is held.
`define BWF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("blur filter check failed");

`endif

// ===== sv/bwf_pkg.sv =====
package bwf_pkg;

  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int PIX_W      = CH_W * NCH;
  localparam int WIN        = 5;
  localparam int NTAP       = WIN * WIN;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int HEIGHT_CAP = 4096;
  localparam int W_RST      = 640;
  localparam int H_RST      = 480;
  localparam int MAX_WIDTH_DEF = 2048;

  // Lane arithmetic: a row sum fits in 12 bits, the biased window sum in 14.
  localparam int ROW_W      = 12;
  localparam int SUM_W      = 14;
  localparam int CEIL_BIAS  = 34;
  // floor(x / 35) == (x * RECIP) >> RECIP_SH for every x below 2^SUM_W.
  localparam int RECIP      = 7490;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 18;
  localparam logic [CH_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [1:0] TAP_WEIGHT [WIN][WIN] = '{
    '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
    '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1},
    '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic            en;
    logic [NTAP-1:0] mask;
  } lane_ctl_t;

endpackage

// ===== sv/bwf_ram.sv =====
module bwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bwf_lane.sv =====
module bwf_lane
  import bwf_pkg::*;
(
  input  logic                       clk_i,
  input  lane_ctl_t                  ctl_i,
  input  logic [NTAP-1:0][CH_W-1:0]  tap_i,
  output logic [CH_W-1:0]            res_o
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [ROW_W-1:0]  row_d [WIN];
  logic [ROW_W-1:0]  row_q [WIN];
  logic [SUM_W-1:0]  tot_d, tot_q;
  logic [PROD_W-1:0] prod;
  logic [CH_W-1:0]   res_d, res_q;

  // Weighted row sums; taps outside the frame are dropped by the mask.
  always_comb begin
    for (int dy = 0; dy < WIN; dy++) begin
      row_d[dy] = '0;
      for (int dx = 0; dx < WIN; dx++) begin
        if (ctl_i.mask[dy*WIN+dx]) begin
          row_d[dy] = row_d[dy] + ROW_W'(tap_i[dy*WIN+dx]) * ROW_W'(TAP_WEIGHT[dy][dx]);
        end
      end
    end
  end

  always_comb begin
    tot_d = SUM_W'(CEIL_BIAS);
    for (int dy = 0; dy < WIN; dy++) begin
      tot_d = tot_d + SUM_W'(row_q[dy]);
    end
  end

  // The bias turns the floor division into the ceiling of the plain sum.
  assign prod  = PROD_W'(tot_q) * PROD_W'(RECIP);
  assign res_d = PIX_MAX - prod[RECIP_SH +: CH_W];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      row_q <= row_d;
      tot_q <= tot_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/blur5x5_invert_filter.sv =====
// Streaming 5x5 weighted blur with inversion for 24-bit pixels in raster order.
// The block takes one item per clock except while the output register, its
// only throttle, backpressures the whole pipeline. A result leaves once the
// item completing its window has passed the input, window, lane and output
// registers. After the W*H pixels of a frame the source sends 2W+2 fill items,
// and the result for pixel p is produced by item p+2W+2. Four line buffers of
// MAX_WIDTH x 24 bits hold earlier rows; three channel lanes sum the window in
// parallel; their results are merged into one output word. Writing a register
// restarts the frame; users write only while the block is idle (unenforced).
module blur5x5_invert_filter
  import bwf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] chan_blue, [15:8] chan_green, [23:16] chan_red
  input  logic [PIX_W-1:0]      s_axis_tdata_i,
  // [0] is_fill
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] res_blue, [15:8] res_green, [23:16] res_red
  output logic [PIX_W-1:0]      m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int QW  = $clog2(MAX_WIDTH * HEIGHT_CAP + 2 * MAX_WIDTH + 3);
  localparam int NLB = WIN - 1;
  localparam int RST_WE    = (W_RST > MAX_WIDTH) ? MAX_WIDTH : W_RST;
  localparam int RST_NPIX  = RST_WE * H_RST;
  localparam int RST_LAG   = 2 * RST_WE + 2;
  localparam int RST_TOTAL = RST_NPIX + RST_LAG;

  logic [CFG_W_W-1:0] fw_q;
  logic [CFG_H_W-1:0] fh_q;
  logic [WW-1:0]      w_eff, w_q;
  logic [CFG_H_W-1:0] h_eff, h_q;
  logic [QW-1:0]      npix_q, lag_q, total_q, qlast_q;

  logic               en, accept, cfg_we, cfg_hit;
  logic [QW-1:0]      q_q;
  logic [AW-1:0]      col_q, cx_q;
  logic [CFG_H_W-1:0] cy_q;
  logic               emit_now, pix_now;
  logic [WIN-1:0]     rowok, colok;
  logic [NTAP-1:0]    mask_now;

  logic               s0_v_q, s0_emit_q, s0_last_q;
  logic [PIX_W-1:0]   s0_pix_q;
  logic [AW-1:0]      s0_col_q;
  logic [NTAP-1:0]    s0_mask_q, m1_q;

  logic [PIX_W-1:0]   lb_rd  [NLB];
  logic [PIX_W-1:0]   lb_eff [NLB];
  logic [PIX_W-1:0]   lb_wd  [NLB];
  logic [PIX_W-1:0]   fwd_dat_q [NLB];
  logic               fwd_q, hazard;

  logic [PIX_W-1:0]   win_q [WIN][WIN];
  logic [3:0]         emit_pipe_q, last_pipe_q;
  lane_ctl_t          lane_ctl;
  logic [CH_W-1:0]    lane_res [NCH];
  logic               out_v_q, out_last_q;
  logic [PIX_W-1:0]   out_dat_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign en          = !out_v_q || m_axis_tready_i;
  assign accept      = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;

  // Out-of-range sizes are clamped into the supported frame.
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = CFG_H_W'(1);
    end else if (32'(fh_q) > HEIGHT_CAP) begin
      h_eff = CFG_H_W'(HEIGHT_CAP);
    end else begin
      h_eff = fh_q;
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_reg_e'(cfg_index_i))
      CFG_FRAME_WIDTH:  cfg_hit = 1'b1;
      CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= CFG_W_W'(W_RST);
      fh_q    <= CFG_H_W'(H_RST);
      w_q     <= WW'(RST_WE);
      h_q     <= CFG_H_W'(H_RST);
      npix_q  <= QW'(RST_NPIX);
      lag_q   <= QW'(RST_LAG);
      total_q <= QW'(RST_TOTAL);
      qlast_q <= QW'(RST_TOTAL - 1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[CFG_W_W-1:0];
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      w_q     <= w_eff;
      h_q     <= h_eff;
      npix_q  <= QW'(w_q) * QW'(h_q);
      lag_q   <= QW'({w_q, 1'b0}) + QW'(2);
      total_q <= npix_q + lag_q;
      qlast_q <= total_q - QW'(1);
    end
  end

  assign pix_now  = q_q < npix_q;
  assign emit_now = (q_q >= lag_q) && (q_q < total_q);

  // Which window rows and columns fall inside the frame for this center.
  always_comb begin
    rowok[0] = cy_q >= CFG_H_W'(2);
    rowok[1] = cy_q >= CFG_H_W'(1);
    rowok[2] = 1'b1;
    rowok[3] = ({1'b0, cy_q} + (CFG_H_W+1)'(1)) < {1'b0, h_q};
    rowok[4] = ({1'b0, cy_q} + (CFG_H_W+1)'(2)) < {1'b0, h_q};
    colok[0] = cx_q >= AW'(2);
    colok[1] = cx_q >= AW'(1);
    colok[2] = 1'b1;
    colok[3] = ((WW+1)'(cx_q) + (WW+1)'(1)) < (WW+1)'(w_q);
    colok[4] = ((WW+1)'(cx_q) + (WW+1)'(2)) < (WW+1)'(w_q);
    for (int dy = 0; dy < WIN; dy++) begin
      for (int dx = 0; dx < WIN; dx++) begin
        mask_now[dy*WIN+dx] = rowok[dy] && colok[dx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q   <= '0;
      col_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (cfg_we && cfg_hit) begin
      q_q   <= '0;
      col_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (accept) begin
      if (q_q == qlast_q) begin
        q_q   <= '0;
        col_q <= '0;
        cx_q  <= '0;
        cy_q  <= '0;
      end else begin
        q_q <= q_q + QW'(1);
        if (WW'(col_q) + WW'(1) == w_q) begin
          col_q <= '0;
        end else begin
          col_q <= col_q + AW'(1);
        end
        if (emit_now) begin
          if (WW'(cx_q) + WW'(1) == w_q) begin
            cx_q <= '0;
            cy_q <= cy_q + CFG_H_W'(1);
          end else begin
            cx_q <= cx_q + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q    <= 1'b0;
      s0_emit_q <= 1'b0;
      s0_last_q <= 1'b0;
    end else if (en) begin
      s0_v_q    <= accept;
      s0_emit_q <= accept && emit_now;
      s0_last_q <= accept && (q_q == qlast_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_pix_q  <= pix_now ? s_axis_tdata_i : '0;
      s0_col_q  <= col_q;
      s0_mask_q <= mask_now;
    end
  end

  // A one-pixel row reads the address that the previous request writes in
  // the same cycle, so that write data is forwarded past the RAM.
  assign hazard = s0_v_q && (s0_col_q == col_q);

  always_comb begin
    for (int k = 0; k < NLB; k++) begin
      lb_eff[k] = fwd_q ? fwd_dat_q[k] : lb_rd[k];
      lb_wd[k]  = (k == 0) ? s0_pix_q : lb_eff[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= hazard;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_dat_q <= lb_wd;
    end
  end

  for (genvar k = 0; k < NLB; k++) begin : g_lb
    bwf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (en && s0_v_q),
      .waddr_i (s0_col_q),
      .wdata_i (lb_wd[k]),
      .re_i    (accept),
      .raddr_i (col_q),
      .rdata_o (lb_rd[k])
    );
  end

  // Column WIN-1 takes the newest item; row 0 is the oldest line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int dy = 0; dy < WIN; dy++) begin
        for (int dx = 0; dx < WIN; dx++) begin
          win_q[dy][dx] <= '0;
        end
      end
    end else if (en && s0_v_q) begin
      for (int dy = 0; dy < WIN; dy++) begin
        for (int dx = 0; dx < WIN-1; dx++) begin
          win_q[dy][dx] <= win_q[dy][dx+1];
        end
        win_q[dy][WIN-1] <= (dy == WIN-1) ? s0_pix_q : lb_eff[NLB-1-((dy < NLB) ? dy : 0)];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s0_v_q) begin
      m1_q <= s0_mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_pipe_q <= '0;
      last_pipe_q <= '0;
    end else if (en) begin
      emit_pipe_q <= {emit_pipe_q[2:0], s0_v_q && s0_emit_q};
      last_pipe_q <= {last_pipe_q[2:0], s0_v_q && s0_last_q};
    end
  end

  assign lane_ctl.en   = en;
  assign lane_ctl.mask = m1_q;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    logic [NTAP-1:0][CH_W-1:0] lane_tap;

    always_comb begin
      for (int t = 0; t < NTAP; t++) begin
        lane_tap[t] = win_q[t/WIN][t%WIN][c*CH_W +: CH_W];
      end
    end

    bwf_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .tap_i (lane_tap),
      .res_o (lane_res[c])
    );
  end

  // Merge the channel lanes into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else if (en) begin
      out_v_q    <= emit_pipe_q[3];
      out_last_q <= last_pipe_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        out_dat_q[c*CH_W +: CH_W] <= lane_res[c];
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== sv/bwf_checker.sv =====
`include "blur5x5_invert_filter_macros.svh"

module bwf_checker
  import bwf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic                  cfg_ready_o
);

  // A pending result is held until it is taken.
  `BWF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // The input side stalls only while a result waits at the output.
  `BWF_ASSERT_IMP(a_in_ready, clk_i, rst_ni, 1'b1, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))

  // A new result only appears after the pipeline has advanced.
  `BWF_ASSERT_IMP(a_out_rise, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(s_axis_tready_o))

  // Configuration writes are never refused.
  `BWF_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, s_axis_tvalid_i || !s_axis_tvalid_i, cfg_ready_o)

endmodule

bind blur5x5_invert_filter bwf_checker u_bwf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .cfg_ready_o     (cfg_ready_o)
);
